// ===== src/acir_pkg.sv =====
`timescale 1ns / 1ps
// Package for the AC remote IR frame encoder: action codes, config record,
// frame constants and byte update tables. No dependencies.
package acir_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int POS_W       = 7;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int DUR_W       = 16;
    localparam int TEMP_W      = 6;

    localparam logic [7:0] TEMP_BASE = 8'd17;

    typedef enum logic [2:0] {
        ACT_POWER = 3'd0,
        ACT_MODE  = 3'd1,
        ACT_TEMP  = 3'd2,
        ACT_FAN   = 3'd3,
        ACT_VANE  = 3'd4,
        ACT_SEND  = 3'd5,
        ACT_NEXT  = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ONE_SPACE    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_TEMP_LOWEST  = 3'd5,
        REG_TEMP_HIGHEST = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_HEAT = 3'd0,
        MODE_COLD = 3'd1,
        MODE_DRY  = 3'd2,
        MODE_AUTO = 3'd3
    } mode_t;

    typedef struct packed {
        logic [DUR_W-1:0]  header_mark_us;
        logic [DUR_W-1:0]  header_space_us;
        logic [DUR_W-1:0]  bit_mark_us;
        logic [DUR_W-1:0]  one_space_us;
        logic [DUR_W-1:0]  zero_space_us;
        logic [TEMP_W-1:0] temp_lowest;
        logic [TEMP_W-1:0] temp_highest;
    } cfg_t;

    localparam logic [7:0] FIXED_HEAD [5] = '{8'h52, 8'hAE, 8'hC3, 8'h26, 8'hD9};

    localparam logic [7:0] MODE_AUTO_BYTE = 8'b0111_1000;
    localparam logic [7:0] MODE_HEAT_BITS = 8'b0000_1100;
    localparam logic [7:0] MODE_DRY_BITS  = 8'b0000_1010;
    localparam logic [7:0] MODE_OTHER_BITS = 8'b0000_1000;
    localparam logic [7:0] POWER_OFF_BITS = 8'b0000_0001;
    localparam logic [7:0] FAN_MASK       = 8'b1110_0000;
    localparam logic [7:0] VANE_MASK      = 8'b0001_1000;

    localparam logic [7:0] FAN_ADD [8] =
        '{8'h40, 8'h60, 8'h80, 8'hC0, 8'h00, 8'hE0, 8'h00, 8'h00};
    localparam logic [7:0] VANE_ADD [8] =
        '{8'h00, 8'h18, 8'h00, 8'h08, 8'h10, 8'h18, 8'h10, 8'h00};
    localparam logic VANE_FLAG [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};

    function automatic logic [7:0] frame_byte(
        input logic [3:0] idx,
        input logic       vane_flag,
        input logic [7:0] fan_vane,
        input logic [7:0] mode_temp
    );
        logic [7:0] b6;
        b6 = {6'd0, vane_flag, 1'b0};
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: frame_byte = FIXED_HEAD[idx[2:0]];
            4'd5:    frame_byte = ~b6;
            4'd6:    frame_byte = b6;
            4'd7:    frame_byte = ~fan_vane;
            4'd8:    frame_byte = fan_vane;
            4'd9:    frame_byte = ~mode_temp;
            4'd10:   frame_byte = mode_temp;
            default: frame_byte = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] apply_mode(input logic [2:0] m, input logic [7:0] cur);
        logic [7:0] hi;
        hi = cur & 8'hF0;
        unique case (m)
            MODE_HEAT: apply_mode = hi | MODE_HEAT_BITS;
            MODE_COLD: apply_mode = hi;
            MODE_DRY:  apply_mode = hi | MODE_DRY_BITS;
            MODE_AUTO: apply_mode = MODE_AUTO_BYTE;
            default:   apply_mode = hi | MODE_OTHER_BITS;
        endcase
    endfunction

endpackage

// ===== src/acir_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the AC remote IR frame encoder: valid/ready plus item fields.
// No dependencies.
interface acir_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       power_on;
    logic [2:0] mode;
    logic [7:0] temperature;
    logic [2:0] fan_speed;
    logic [2:0] vane;

    modport source (output valid, action, power_on, mode, temperature, fan_speed, vane,
                    input ready);
    modport sink   (input valid, action, power_on, mode, temperature, fan_speed, vane,
                    output ready);
endinterface

// ===== src/acir_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the AC remote IR frame encoder: valid/ready plus one
// mark/space pair. No dependencies.
interface acir_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] mark_us;
    logic [15:0] space_us;
    logic        last;

    modport source (output valid, mark_us, space_us, last, input ready);
    modport sink   (input valid, mark_us, space_us, last, output ready);
endinterface

// ===== src/acir_regs.sv =====
`timescale 1ns / 1ps
// APB register file for the AC remote IR frame encoder timing and limits.
// Depends on acir_pkg.
module acir_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acir_pkg::ADDR_W-1:0]   paddr,
    input  logic [acir_pkg::DATA_W-1:0]   pwdata,
    output logic [acir_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output acir_pkg::cfg_t                cfg
);

    acir_pkg::cfg_t     cfg_reg;
    acir_pkg::reg_index_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = acir_pkg::reg_index_t'(paddr[acir_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark_us  <= 16'd3400;
            cfg_reg.header_space_us <= 16'd1750;
            cfg_reg.bit_mark_us     <= 16'd450;
            cfg_reg.one_space_us    <= 16'd1300;
            cfg_reg.zero_space_us   <= 16'd420;
            cfg_reg.temp_lowest     <= 6'd17;
            cfg_reg.temp_highest    <= 6'd31;
        end
        else if (wr_en)
        begin
            unique case (idx)
                acir_pkg::REG_HEADER_MARK:  cfg_reg.header_mark_us  <= pwdata[15:0];
                acir_pkg::REG_HEADER_SPACE: cfg_reg.header_space_us <= pwdata[15:0];
                acir_pkg::REG_BIT_MARK:     cfg_reg.bit_mark_us     <= pwdata[15:0];
                acir_pkg::REG_ONE_SPACE:    cfg_reg.one_space_us    <= pwdata[15:0];
                acir_pkg::REG_ZERO_SPACE:   cfg_reg.zero_space_us   <= pwdata[15:0];
                acir_pkg::REG_TEMP_LOWEST:  cfg_reg.temp_lowest     <= pwdata[5:0];
                acir_pkg::REG_TEMP_HIGHEST: cfg_reg.temp_highest    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            acir_pkg::REG_HEADER_MARK:  prdata = {16'd0, cfg_reg.header_mark_us};
            acir_pkg::REG_HEADER_SPACE: prdata = {16'd0, cfg_reg.header_space_us};
            acir_pkg::REG_BIT_MARK:     prdata = {16'd0, cfg_reg.bit_mark_us};
            acir_pkg::REG_ONE_SPACE:    prdata = {16'd0, cfg_reg.one_space_us};
            acir_pkg::REG_ZERO_SPACE:   prdata = {16'd0, cfg_reg.zero_space_us};
            acir_pkg::REG_TEMP_LOWEST:  prdata = {26'd0, cfg_reg.temp_lowest};
            acir_pkg::REG_TEMP_HIGHEST: prdata = {26'd0, cfg_reg.temp_highest};
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== src/ac_remote_ir_frame_encoder.sv =====
`timescale 1ns / 1ps
// AC remote IR frame encoder, top level.
// Depends on acir_pkg, acir_in_if, acir_out_if and acir_regs.
//
// Usage: set items (power, mode, temperature, fan, vane) on the input channel
// edit the 11-byte frame; a send item starts a transmission and returns the
// header mark/space pair; each next item returns one bit pair, LSB of byte 0
// first, 88 in all, then one more next item returns the trailer mark with
// last set. Set and send items during a transmission, and next items outside
// one, are absorbed without a result.
// Timing: an accepted item is captured in the input register, then the
// frame logic updates state and loads the output register, which offers
// the result on the output channel. One item per cycle is sustained while the
// receiver takes each result; the bit select and byte masks fit in one stage.
// Reset clears the frame to its default content, ends any transmission and
// restores the register defaults. When the receiver stalls, the output
// register holds its pair and the input register holds one more item; the
// input stays ready while either stage can move. The user must write
// registers through the APB port only while idle; the block has no check for it.
module ac_remote_ir_frame_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acir_pkg::ADDR_W-1:0]   paddr,
    input  logic [acir_pkg::DATA_W-1:0]   pwdata,
    output logic [acir_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    acir_in_if.sink                       in,
    acir_out_if.source                    out
);

    acir_pkg::cfg_t cfg;

    acir_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic       in_valid_reg;
    logic [2:0] action_reg;
    logic       power_on_reg;
    logic [2:0] mode_reg;
    logic [7:0] temperature_reg;
    logic [2:0] fan_speed_reg;
    logic [2:0] vane_reg;

    // frame state
    logic                         vane_flag_reg, vane_flag_next;
    logic [7:0]                   fan_vane_reg, fan_vane_next;
    logic [7:0]                   mode_temp_reg, mode_temp_next;
    logic                         sending_reg, sending_next;
    logic [acir_pkg::POS_W-1:0]   bit_pos_reg, bit_pos_next;

    // output register
    logic        out_valid_reg;
    logic [15:0] mark_reg;
    logic [15:0] space_reg;
    logic        last_reg;

    logic        out_free;
    logic        proc;
    logic        res_valid;
    logic [15:0] res_mark;
    logic [15:0] res_space;
    logic        res_last;
    logic [7:0]  cur_byte;
    logic        cur_bit;
    logic [7:0]  temp_clamped;
    logic [7:0]  temp_offset;

    assign out_free = !out_valid_reg || out.ready;
    assign proc     = in_valid_reg && out_free;
    assign in.ready = !in_valid_reg || out_free;

    assign out.valid    = out_valid_reg;
    assign out.mark_us  = mark_reg;
    assign out.space_us = space_reg;
    assign out.last     = last_reg;

    always_comb
    begin
        cur_byte = acir_pkg::frame_byte(bit_pos_reg[acir_pkg::POS_W-1:3], vane_flag_reg,
                                        fan_vane_reg, mode_temp_reg);
        cur_bit  = cur_byte[bit_pos_reg[2:0]];

        priority if (temperature_reg >= {2'd0, cfg.temp_highest})
            temp_clamped = {2'd0, cfg.temp_highest};
        else if (temperature_reg < {2'd0, cfg.temp_lowest})
            temp_clamped = {2'd0, cfg.temp_lowest};
        else
            temp_clamped = temperature_reg;
        temp_offset = temp_clamped - acir_pkg::TEMP_BASE;
    end

    always_comb
    begin
        vane_flag_next = vane_flag_reg;
        fan_vane_next  = fan_vane_reg;
        mode_temp_next = mode_temp_reg;
        sending_next   = sending_reg;
        bit_pos_next   = bit_pos_reg;
        res_valid      = 1'b0;
        res_mark       = cfg.bit_mark_us;
        res_space      = 16'd0;
        res_last       = 1'b0;

        if (proc)
        begin
            if (action_reg == acir_pkg::ACT_NEXT)
            begin
                if (sending_reg)
                begin
                    res_valid = 1'b1;
                    if (bit_pos_reg < acir_pkg::POS_W'(acir_pkg::FRAME_BITS))
                    begin
                        res_space    = cur_bit ? cfg.one_space_us : cfg.zero_space_us;
                        bit_pos_next = bit_pos_reg + acir_pkg::POS_W'(1);
                    end
                    else
                    begin
                        res_last     = 1'b1;
                        sending_next = 1'b0;
                        bit_pos_next = '0;
                    end
                end
            end
            else if (!sending_reg)
            begin
                unique case (action_reg)
                    acir_pkg::ACT_POWER:
                    begin
                        if (power_on_reg)
                            mode_temp_next = acir_pkg::apply_mode(mode_reg, mode_temp_reg);
                        else
                            mode_temp_next = (mode_temp_reg & 8'hF0) | acir_pkg::POWER_OFF_BITS;
                    end
                    acir_pkg::ACT_MODE:
                        mode_temp_next = acir_pkg::apply_mode(mode_reg, mode_temp_reg);
                    acir_pkg::ACT_TEMP:
                        mode_temp_next = {temp_offset[3:0], mode_temp_reg[3:0]};
                    acir_pkg::ACT_FAN:
                        fan_vane_next = (fan_vane_reg & ~acir_pkg::FAN_MASK)
                                      | acir_pkg::FAN_ADD[fan_speed_reg];
                    acir_pkg::ACT_VANE:
                    begin
                        fan_vane_next = (fan_vane_reg & ~acir_pkg::VANE_MASK)
                                      | acir_pkg::VANE_ADD[vane_reg];
                        if (vane_reg != 3'd7)
                            vane_flag_next = acir_pkg::VANE_FLAG[vane_reg];
                    end
                    acir_pkg::ACT_SEND:
                    begin
                        sending_next = 1'b1;
                        bit_pos_next = '0;
                        res_valid    = 1'b1;
                        res_mark     = cfg.header_mark_us;
                        res_space    = cfg.header_space_us;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            vane_flag_reg <= 1'b1;
            fan_vane_reg  <= 8'h80;
            mode_temp_reg <= 8'h21;
            sending_reg   <= 1'b0;
            bit_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in.ready)
                in_valid_reg <= in.valid;
            vane_flag_reg <= vane_flag_next;
            fan_vane_reg  <= fan_vane_next;
            mode_temp_reg <= mode_temp_next;
            sending_reg   <= sending_next;
            bit_pos_reg   <= bit_pos_next;
            if (out_free)
                out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
        begin
            action_reg      <= in.action;
            power_on_reg    <= in.power_on;
            mode_reg        <= in.mode;
            temperature_reg <= in.temperature;
            fan_speed_reg   <= in.fan_speed;
            vane_reg        <= in.vane;
        end
        if (res_valid)
        begin
            mark_reg  <= res_mark;
            space_reg <= res_space;
            last_reg  <= res_last;
        end
    end

endmodule
